// ===== design/spq_pkg.sv =====
// spq_pkg: types and constants shared by the sorted priority queue modules
// no dependencies

package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] key;
      logic [15:0]        process_id;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] out_key;
      logic [15:0]        out_id;
      logic               rejected;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic apply;
   } ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

endpackage

// ===== design/spq_ctrl.sv =====
// spq_ctrl: two-state sequencer, capture an item then apply it to the queue
// depends on spq_pkg

module spq_ctrl import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output ctl_type ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.capture = 1'b0;
      ctl.apply   = 1'b0;
      busy        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.capture = start;
         end
         ST_APPLY: begin
            ctl.apply = 1'b1;
            busy      = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

// ===== design/spq_datapath.sv =====
// spq_datapath: shift-register row of sorted entries with per-slot compare
// depends on spq_pkg; driven by spq_ctrl

module spq_datapath import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  ctl_type ctl,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [31:0] keys_ff [DEPTH];
   logic signed [31:0] keys_in [DEPTH];
   logic [15:0]        ids_ff  [DEPTH];
   logic [15:0]        ids_in  [DEPTH];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   req_type            req_ff;
   logic [DEPTH-1:0]   stay_ff;
   logic [DEPTH-1:0]   stay_in;
   logic [DEPTH-1:0]   match_ff;
   logic [DEPTH-1:0]   match_in;
   logic [DEPTH-1:0]   valid;
   logic [DEPTH-1:0]   hit_prefix;
   logic               rsp_strobe_ff;
   rsp_type            rsp_item_ff;
   rsp_type            rsp_in;
   logic [31:0]        count_wide;

   // per-slot compares against the incoming item, taken at capture
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid[i]    = CW'(i) < count_ff;
         stay_in[i]  = valid[i] && !(req_item.key < keys_ff[i]);
         match_in[i] = valid[i] && (ids_ff[i] == req_item.process_id);
      end
   end

   // slots at and after the first id match, log-depth prefix or
   always_comb begin
      hit_prefix = match_ff;
      for (int s = 1; s < DEPTH; s = s * 2) begin
         hit_prefix = hit_prefix | (hit_prefix << s);
      end
   end

   always_comb begin
      keys_in  = keys_ff;
      ids_in   = ids_ff;
      count_in = count_ff;
      rsp_in   = '0;
      unique case (req_ff.operation)
         OP_INSERT: begin
            if (count_ff == CW'(DEPTH)) begin
               rsp_in.rejected = 1'b1;
            end else begin
               // each slot keeps, takes the new item, or takes its left neighbor
               if (!stay_ff[0]) begin
                  keys_in[0] = req_ff.key;
                  ids_in[0]  = req_ff.process_id;
               end
               for (int i = 1; i < DEPTH; i++) begin
                  if (!stay_ff[i]) begin
                     if (stay_ff[i-1]) begin
                        keys_in[i] = req_ff.key;
                        ids_in[i]  = req_ff.process_id;
                     end else begin
                        keys_in[i] = keys_ff[i-1];
                        ids_in[i]  = ids_ff[i-1];
                     end
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
         OP_POP: begin
            if (count_ff != '0) begin
               rsp_in.found   = 1'b1;
               rsp_in.out_key = keys_ff[0];
               rsp_in.out_id  = ids_ff[0];
               for (int i = 0; i < DEPTH - 1; i++) begin
                  keys_in[i] = keys_ff[i+1];
                  ids_in[i]  = ids_ff[i+1];
               end
               count_in = count_ff - CW'(1);
            end
         end
         OP_REMOVE: begin
            if (|match_ff) begin
               rsp_in.found  = 1'b1;
               rsp_in.out_id = req_ff.process_id;
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (hit_prefix[i]) begin
                     keys_in[i] = keys_ff[i+1];
                     ids_in[i]  = ids_ff[i+1];
                  end
               end
               count_in = count_ff - CW'(1);
            end
         end
         default: ;
      endcase
      count_wide         = 32'(count_in);
      rsp_in.entry_count = count_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.apply;
         if (ctl.apply) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff   <= req_item;
         stay_ff  <= stay_in;
         match_ff <= match_in;
      end
      if (ctl.apply) begin
         keys_ff     <= keys_in;
         ids_ff      <= ids_in;
         rsp_item_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("entry count above depth");

   a_strobe_after_apply: assert property (@(posedge clock) disable iff (reset)
      ctl.apply |=> rsp_strobe_ff)
      else $error("apply gave no result strobe");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !ctl.apply |=> $stable(count_ff))
      else $error("count changed outside apply");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      ctl.apply && rsp_in.rejected |-> count_ff == CW'(DEPTH) && !rsp_in.found)
      else $error("reject while not full");
`endif

endmodule

// ===== design/sorted_priority_queue.sv =====
// sorted_priority_queue: top level, sequencer plus sorted entry row
// depends on spq_pkg, spq_ctrl, spq_datapath
//
//   channel   ports                    handshake
//   request   req_item                 taken when start && !busy
//   response  rsp_item                 valid for the one cycle rsp_strobe is high
//
// every item is first compared against all slots, then the row is shifted;
// the result shows in the cycle after, while the next item may already be taken.
// reset clears the entry count; slot contents need no clearing.
// the receiver cannot stall, each result is shown exactly once.

module sorted_priority_queue import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   ctl_type ctl;

   spq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
// sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// depends on spq_pkg and sorted_priority_queue; a queue-fed driver and a
// strobe monitor check every result against an in-bench model of the entry row

module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int SLOTS = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int RANDOM_OPS = 650;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      req_type     item;
      int unsigned gap_pct;
   } pending_op_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   pending_op_type ops_to_send[$];
   rsp_type        results_due[$];
   int             mismatch_total = 0;
   int             cycle_count = 0;

   // model of the sorted entry row
   logic signed [31:0] held_key [SLOTS];
   logic [15:0]        held_id [SLOTS];
   int                 held_total = 0;

   sorted_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // close the gap left by the entry at pos
   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < held_total; i++) begin
         held_key[i] = held_key[i + 1];
         held_id[i] = held_id[i + 1];
      end
      held_total--;
   endfunction

   function automatic rsp_type predict_queue_op(req_type op_in);
      rsp_type rsp;
      int      pos;
      rsp = '0;
      case (op_in.operation)
         OP_INSERT: begin
            if (held_total >= SLOTS) begin
               rsp.rejected = 1'b1;
            end else begin
               // equal keys keep arrival order
               pos = 0;
               while (pos < held_total && !(op_in.key < held_key[pos])) pos++;
               for (int i = held_total; i > pos; i--) begin
                  held_key[i] = held_key[i - 1];
                  held_id[i] = held_id[i - 1];
               end
               held_key[pos] = op_in.key;
               held_id[pos] = op_in.process_id;
               held_total++;
            end
         end
         OP_POP: begin
            if (held_total > 0) begin
               rsp.found = 1'b1;
               rsp.out_key = held_key[0];
               rsp.out_id = held_id[0];
               drop_slot(0);
            end
         end
         OP_REMOVE: begin
            for (pos = 0; pos < held_total; pos++) begin
               if (held_id[pos] == op_in.process_id) begin
                  rsp.found = 1'b1;
                  rsp.out_id = op_in.process_id;
                  drop_slot(pos);
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      rsp.entry_count = 5'(held_total);
      return rsp;
   endfunction

   function automatic void queue_op(logic [1:0] op, logic signed [31:0] key,
                                    logic [15:0] pid, int unsigned gap_pct);
      pending_op_type slot;
      slot.item.operation = op;
      slot.item.key = key;
      slot.item.process_id = pid;
      slot.gap_pct = gap_pct;
      ops_to_send.push_back(slot);
   endfunction

   // half the time a narrow band around zero so equal keys are common
   function automatic logic signed [31:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 5) return $urandom_range(12) - 6;
      if (roll < 8) return $urandom;
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0001;
         default: return 32'h7FFF_FFFE;
      endcase
   endfunction

   // small ids make removes hit held entries often
   function automatic logic [15:0] pick_id();
      if ($urandom_range(9) < 7) return 16'($urandom_range(23));
      return 16'($urandom_range(65535));
   endfunction

   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_total++;
      if (mismatch_total <= 10) begin
         $display("mismatch %s: expected found=%0b key=%0d id=%0h rej=%0b count=%0d",
                  what, want.found, want.out_key, want.out_id, want.rejected,
                  want.entry_count);
         $display("         got      found=%0b key=%0d id=%0h rej=%0b count=%0d",
                  got.found, got.out_key, got.out_id, got.rejected, got.entry_count);
      end
   endfunction

   always @(posedge clock) begin : drive_ops
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            results_due.push_back(predict_queue_op(req_item));
            next_start = 1'b0;
         end
         if (!next_start && ops_to_send.size() != 0) begin
            if ($urandom_range(99) >= ops_to_send[0].gap_pct) begin
               req_item <= ops_to_send[0].item;
               void'(ops_to_send.pop_front());
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      string   bad;
      if (!reset && rsp_strobe) begin
         if (results_due.size() == 0) begin
            report_mismatch("unexpected item", '0, rsp_item);
         end else begin
            want = results_due.pop_front();
            bad = "";
            if (rsp_item.found !== want.found) bad = {bad, " found"};
            if (rsp_item.out_key !== want.out_key) bad = {bad, " out_key"};
            if (rsp_item.out_id !== want.out_id) bad = {bad, " out_id"};
            if (rsp_item.rejected !== want.rejected) bad = {bad, " rejected"};
            if (rsp_item.entry_count !== want.entry_count) bad = {bad, " entry_count"};
            if (bad != "") report_mismatch(bad, want, rsp_item);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_priority_queue_tb failed");
         $finish;
      end
   end

   initial begin : build_stimulus
      int unsigned phase_gap [4];
      int          sent;
      int unsigned mode;
      int unsigned burst;
      int unsigned roll;
      logic [1:0]  op;
      phase_gap = '{0, 53, 0, 15};

      // directed: empty cases, extremes, equal keys, removes, unused code
      queue_op(OP_POP, 32'sd0, 16'h0000, 0);
      queue_op(OP_REMOVE, 32'sd0, 16'h0000, 0);
      queue_op(OP_UNUSED, 32'sd0, 16'h0000, 0);
      queue_op(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 0);
      queue_op(OP_INSERT, 32'h8000_0000, 16'h0000, 0);
      queue_op(OP_INSERT, 32'sd5, 16'h0001, 0);
      queue_op(OP_INSERT, 32'sd5, 16'h0002, 0);
      queue_op(OP_INSERT, 32'sd5, 16'h0003, 0);
      queue_op(OP_INSERT, -32'sd1, 16'h0004, 0);
      queue_op(OP_INSERT, 32'sd0, 16'h0005, 0);
      queue_op(OP_REMOVE, 32'sd0, 16'h0002, 0);
      queue_op(OP_REMOVE, 32'sd0, 16'h0063, 0);
      queue_op(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 0);
      queue_op(OP_POP, 32'sd0, 16'h0000, 0);
      queue_op(OP_POP, 32'sd0, 16'h0000, 0);
      queue_op(OP_POP, 32'sd0, 16'h0000, 0);
      queue_op(OP_POP, 32'sd0, 16'h0000, 0);
      queue_op(OP_POP, 32'sd0, 16'h0000, 0);
      queue_op(OP_REMOVE, 32'sd0, 16'hFFFF, 0);
      queue_op(OP_POP, 32'sd0, 16'h0000, 0);

      // random bursts that fill, drain or mix, so full and empty both recur
      sent = 0;
      while (sent < RANDOM_OPS) begin
         mode = $urandom_range(2);
         burst = $urandom_range(6, 30);
         repeat (burst) begin
            roll = $urandom_range(99);
            case (mode)
               0: op = roll < 75 ? OP_INSERT : roll < 87 ? OP_POP :
                       roll < 97 ? OP_REMOVE : OP_UNUSED;
               1: op = roll < 15 ? OP_INSERT : roll < 65 ? OP_POP :
                       roll < 97 ? OP_REMOVE : OP_UNUSED;
               default: op = roll < 40 ? OP_INSERT : roll < 70 ? OP_POP :
                             roll < 96 ? OP_REMOVE : OP_UNUSED;
            endcase
            // the last burst may run past the target, it stays in the last phase
            queue_op(op, pick_key(), pick_id(),
                     phase_gap[(sent < RANDOM_OPS) ? (sent * 4) / RANDOM_OPS : 3]);
            if (op != OP_UNUSED) sent++;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (ops_to_send.size() != 0 || start || results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_total == 0) begin
         $display("sorted_priority_queue_tb passed");
      end else begin
         $display("sorted_priority_queue_tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
